// ===== design/rc256_pkg.sv =====
// Shared types, codes and sizing constants for the base-256 radix converter.
// No dependencies; imported by rc256_alu, radix_converter_base256 and the bench.
package rc256_pkg;

    localparam int MAX_LEN  = 24;
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int DIG_AW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    // Worst case result count of the long division, with some margin.
    localparam int OUT_CAP  = (MAX_LEN * 2409) / 1000 + 13;
    localparam int OUT_AW   = $clog2(OUT_CAP);

    // Mode register codes.
    localparam logic [1:0] MODE_DEC       = 2'd0;
    localparam logic [1:0] MODE_HEX       = 2'd1;
    localparam logic [1:0] MODE_BYTES     = 2'd2;
    localparam logic [1:0] MODE_BYTES_ALT = 2'd3;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_CHAR = 2'd1,
        ERR_TOO_LONG = 2'd2
    } t_err_kind;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;

    // Reciprocal of ten for acc < 43699: q = (acc * DIV10_MUL) >> DIV10_SHIFT.
    localparam int DIV10_MUL   = 52429;
    localparam int DIV10_SHIFT = 19;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] value;
        logic       end_of_run;
        logic [1:0] error_kind;
    } t_out_item;

    // Operands of the digit unit.
    typedef struct packed {
        logic [1:0] dmode;   // mode for symbol decode
        logic [1:0] cmode;   // mode for conversion
        logic [7:0] symbol;
        logic [7:0] digit;
        logic [7:0] rem;
        logic [3:0] hi;
    } t_alu_in;

    typedef struct packed {
        logic       sym_ok;
        logic [7:0] sym_val;
        logic [7:0] quot;
        logic [7:0] rem_nxt;
        logic [7:0] hex_byte;
    } t_alu_out;

endpackage

// ===== design/rc256_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module rc256_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 24,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        // hold the last read word while no read is issued
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rc256_alu.sv =====
// Digit unit: symbol decode, one long-division step by 256 or by 10, hex packing.
// Depends on rc256_pkg.
module rc256_alu
    import rc256_pkg::*;
(
    input  t_alu_in  i_alu,
    output t_alu_out o_alu
);

    logic [11:0] acc_dec;
    logic [11:0] acc_byt;
    logic [27:0] prod;
    logic [7:0]  quot_byt;
    logic [11:0] rem_byt;

    // decode the incoming symbol
    always_comb begin
        o_alu.sym_ok  = 1'b0;
        o_alu.sym_val = 8'd0;
        if (i_alu.dmode inside {MODE_BYTES, MODE_BYTES_ALT}) begin
            o_alu.sym_ok  = 1'b1;
            o_alu.sym_val = i_alu.symbol;
        end else if (i_alu.symbol inside {[CH_0:CH_9]}) begin
            o_alu.sym_ok  = 1'b1;
            o_alu.sym_val = i_alu.symbol - CH_0;
        end else if (i_alu.dmode == MODE_HEX && (i_alu.symbol inside {[CH_UA:CH_UF]})) begin
            o_alu.sym_ok  = 1'b1;
            o_alu.sym_val = i_alu.symbol - CH_UA + 8'd10;
        end else if (i_alu.dmode == MODE_HEX && (i_alu.symbol inside {[CH_LA:CH_LF]})) begin
            o_alu.sym_ok  = 1'b1;
            o_alu.sym_val = i_alu.symbol - CH_LA + 8'd10;
        end
    end

    // decimal digits divided by 256: shift and mask
    assign acc_dec  = 12'(i_alu.rem) * 12'd10 + 12'(i_alu.digit);
    // bytes divided by 10: remainder stays below ten, so it fits four bits
    assign acc_byt  = {i_alu.rem[3:0], i_alu.digit};
    assign prod     = 28'(acc_byt) * 28'(DIV10_MUL);
    assign quot_byt = prod[DIV10_SHIFT +: 8];
    assign rem_byt  = acc_byt - 12'(quot_byt) * 12'd10;

    always_comb begin
        if (i_alu.cmode inside {MODE_BYTES, MODE_BYTES_ALT}) begin
            o_alu.quot    = quot_byt;
            o_alu.rem_nxt = rem_byt[7:0];
        end else begin
            o_alu.quot    = {4'd0, acc_dec[11:8]};
            o_alu.rem_nxt = acc_dec[7:0];
        end
    end

    assign o_alu.hex_byte = {i_alu.hi, 4'd0} + i_alu.digit;

endmodule

// ===== design/radix_converter_base256.sv =====
// Top level of the radix converter: load sequencer, division passes and result emitter.
// Depends on rc256_pkg, rc256_ram (digit store, result store) and rc256_alu.
//
//  channel  | valid    | ready    | payload
//  ---------+----------+----------+-----------------------------
//  input    | i_valid  | o_ready  | i_in  (symbol, last)
//  output   | o_valid  | i_ready  | o_out (value, end_of_run, error_kind)
//  config   | i_cfg_we | -        | i_cfg_data (mode)
//
// Loading takes one symbol per cycle while the block is in its load state. After the
// last symbol each long-division pass streams the digit store through its read port
// at one digit a cycle; decimal and byte modes run one pass per result, hex runs a
// single packing pass. Each result is then read from the result store and loaded
// into the output register. An error run gives its one result without passes.
// Reset is synchronous; no store is cleared. A stalled output holds the block in
// the emitter or error state, but the next number may start loading while the final result waits.
module radix_converter_base256
    import rc256_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_data,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_in,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_out
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_ERR
    } t_state;

    t_state           r_state;
    logic [1:0]       r_mode;
    logic [1:0]       r_cmode;
    logic [CNT_W-1:0] r_count;
    t_err_kind        r_err;
    t_err_kind        r_ekind;
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] r_rd_idx;
    logic [CNT_W-1:0] r_nlen;
    logic             r_dv;
    logic [7:0]       r_rem;
    logic [3:0]       r_hi;
    logic             r_half;
    logic [OUT_AW-1:0] r_optr;
    logic [OUT_AW-1:0] r_oidx;
    logic             r_out_vld;
    t_out_item        r_out;

    logic             in_xfer;
    logic             out_free;
    logic             issue;
    logic             pass_done;
    logic             hex;
    logic             keep;
    logic             full;
    t_err_kind        n_err;
    logic [CNT_W-1:0] n_count;
    logic             out_load;
    t_out_item        n_out;

    logic              dig_we;
    logic [DIG_AW-1:0] dig_waddr;
    logic [7:0]        dig_wdata;
    logic              dig_re;
    logic [DIG_AW-1:0] dig_raddr;
    logic [7:0]        dig_rdata;
    logic              res_we;
    logic [OUT_AW-1:0] res_waddr;
    logic [7:0]        res_wdata;
    logic              res_re;
    logic [7:0]        res_rdata;

    t_alu_in  alu_i;
    t_alu_out alu_o;

    rc256_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_digits (
        .i_clk   (i_clk),
        .i_we    (dig_we),
        .i_waddr (dig_waddr),
        .i_wdata (dig_wdata),
        .i_re    (dig_re),
        .i_raddr (dig_raddr),
        .o_rdata (dig_rdata)
    );

    rc256_ram #(.WIDTH(8), .DEPTH(OUT_CAP)) u_results (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (res_waddr),
        .i_wdata (res_wdata),
        .i_re    (res_re),
        .i_raddr (r_oidx),
        .o_rdata (res_rdata)
    );

    assign alu_i.dmode  = r_mode;
    assign alu_i.cmode  = r_cmode;
    assign alu_i.symbol = i_in.symbol;
    assign alu_i.digit  = dig_rdata;
    assign alu_i.rem    = r_rem;
    assign alu_i.hi     = r_hi;

    rc256_alu u_alu (
        .i_alu (alu_i),
        .o_alu (alu_o)
    );

    assign o_ready = (r_state == ST_LOAD);
    assign o_valid = r_out_vld;
    assign o_out   = r_out;

    always_comb begin
        in_xfer   = i_valid && o_ready;
        out_free  = !r_out_vld || i_ready;
        issue     = (r_state == ST_PASS) && (r_rd_idx < r_len);
        pass_done = (r_state == ST_PASS) && !issue && !r_dv;
        hex       = (r_cmode == MODE_HEX);
        keep      = (alu_o.quot != 8'd0) || (r_nlen != '0);

        // symbol bookkeeping; the first error of a run wins
        full  = (r_count >= CNT_W'(MAX_LEN));
        n_err = r_err;
        if (full) begin
            if (r_err == ERR_NONE) n_err = ERR_TOO_LONG;
        end else if (!alu_o.sym_ok && r_err == ERR_NONE) begin
            n_err = ERR_BAD_CHAR;
        end
        n_count = full ? r_count : r_count + 1'b1;

        dig_we    = 1'b0;
        dig_waddr = r_count[DIG_AW-1:0];
        dig_wdata = alu_o.sym_val;
        if (r_state == ST_LOAD) begin
            dig_we = in_xfer && !full;
        end else if (r_state == ST_PASS) begin
            // quotient digits land at or below the digit just read
            dig_we    = r_dv && !hex && keep;
            dig_waddr = r_nlen[DIG_AW-1:0];
            dig_wdata = alu_o.quot;
        end
        dig_re    = issue;
        dig_raddr = r_rd_idx[DIG_AW-1:0];

        res_we    = 1'b0;
        res_waddr = r_optr;
        res_wdata = alu_o.hex_byte;
        if (r_dv && hex && r_half) begin
            res_we = 1'b1;
        end else if (pass_done && !hex) begin
            res_we    = 1'b1;
            res_wdata = (r_cmode == MODE_DEC) ? r_rem : r_rem + CH_0;
        end
        res_re = (r_state == ST_EMIT_RD);

        out_load = 1'b0;
        n_out    = '0;
        if (r_state == ST_EMIT_WR) begin
            out_load         = out_free;
            n_out.value      = res_rdata;
            n_out.end_of_run = (r_oidx == '0);
            n_out.error_kind = ERR_NONE;
        end else if (r_state == ST_ERR) begin
            out_load         = out_free;
            n_out.value      = 8'd0;
            n_out.end_of_run = 1'b1;
            n_out.error_kind = r_ekind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_mode    <= MODE_DEC;
            r_count   <= '0;
            r_err     <= ERR_NONE;
            r_dv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end

            if (out_load) begin
                r_out     <= n_out;
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_LOAD: begin
                    if (in_xfer) begin
                        r_count <= i_in.last ? '0 : n_count;
                        r_err   <= i_in.last ? ERR_NONE : n_err;
                        if (i_in.last) begin
                            r_ekind  <= n_err;
                            r_len    <= n_count;
                            r_cmode  <= r_mode;
                            r_rd_idx <= '0;
                            r_dv     <= 1'b0;
                            r_rem    <= 8'd0;
                            r_nlen   <= '0;
                            r_hi     <= 4'd0;
                            r_half   <= n_count[0];
                            r_optr   <= (r_mode == MODE_HEX) ?
                                        OUT_AW'((n_count - 1'b1) >> 1) : '0;
                            r_state  <= (n_err != ERR_NONE) ? ST_ERR : ST_PASS;
                        end
                    end
                end
                ST_PASS: begin
                    r_dv <= issue;
                    if (issue) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    if (r_dv) begin
                        if (hex) begin
                            if (r_half) begin
                                r_optr <= r_optr - 1'b1;
                                r_half <= 1'b0;
                            end else begin
                                r_hi   <= dig_rdata[3:0];
                                r_half <= 1'b1;
                            end
                        end else begin
                            r_rem <= alu_o.rem_nxt;
                            if (keep) r_nlen <= r_nlen + 1'b1;
                        end
                    end
                    if (pass_done) begin
                        if (hex) begin
                            r_oidx  <= OUT_AW'((r_len - 1'b1) >> 1);
                            r_state <= ST_EMIT_RD;
                        end else begin
                            // advance to the next pass on the shortened quotient
                            r_optr   <= r_optr + 1'b1;
                            r_oidx   <= r_optr;
                            r_len    <= r_nlen;
                            r_nlen   <= '0;
                            r_rem    <= 8'd0;
                            r_rd_idx <= '0;
                            if (r_nlen == '0) r_state <= ST_EMIT_RD;
                        end
                    end
                end
                ST_EMIT_RD: begin
                    r_state <= ST_EMIT_WR;
                end
                ST_EMIT_WR: begin
                    if (out_free) begin
                        if (r_oidx == '0) begin
                            r_state <= ST_LOAD;
                        end else begin
                            r_oidx  <= r_oidx - 1'b1;
                            r_state <= ST_EMIT_RD;
                        end
                    end
                end
                ST_ERR: begin
                    if (out_free) r_state <= ST_LOAD;
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    // The symbol count never passes the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("digit count beyond store depth");

    // A quotient write during a pass never hits the entry being read.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS && dig_we && dig_re) |-> (dig_waddr != dig_raddr))
        else $error("digit store read and write collide");

    // Loading the final result of a run hands control back to loading.
    a_eor_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_out.end_of_run) |=> (r_state == ST_LOAD))
        else $error("run did not end after its final result");

    // An error result carries a zero value and ends its run.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.error_kind != ERR_NONE) |->
        (r_out.value == 8'd0 && r_out.end_of_run))
        else $error("malformed error result");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for radix_converter_base256: directed and random runs in every mode, checked
// against a cycle-free predictor of the conversion. Depends on rc256_pkg and the RTL.

import rc256_pkg::*;

class conversion_board;
    logic [7:0]  digits[MAX_LEN];
    int unsigned n_digits;
    t_err_kind   err_seen;
    logic [1:0]  mode;
    t_out_item   out_wanted[$];
    int unsigned rem_digits[$];
    int unsigned mismatches;

    function new();
        n_digits   = 0;
        err_seen   = ERR_NONE;
        mode       = MODE_DEC;
        mismatches = 0;
    endfunction

    function void set_mode(input logic [1:0] m);
        mode = m;
    endfunction

    function int unsigned pending();
        return out_wanted.size();
    endfunction

    function bit symbol_digit(input logic [1:0] m, input logic [7:0] s, output logic [7:0] v);
        v = 8'd0;
        if (m >= MODE_BYTES) begin
            v = s;
            return 1'b1;
        end
        if (s >= CH_0 && s <= CH_9) begin
            v = s - CH_0;
            return 1'b1;
        end
        if (m == MODE_HEX) begin
            if (s >= CH_UA && s <= CH_UF) begin
                v = s - CH_UA + 8'd10;
                return 1'b1;
            end
            if (s >= CH_LA && s <= CH_LF) begin
                v = s - CH_LA + 8'd10;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Repeated long division of the held number; remainders end up most significant first.
    function void long_divide(input int unsigned radix_in, input int unsigned divisor);
        int unsigned work[MAX_LEN];
        int unsigned len;
        int unsigned nlen;
        int unsigned rem;
        int unsigned acc;
        rem_digits.delete();
        len = n_digits;
        for (int i = 0; i < MAX_LEN; i++) begin
            work[i] = (i < len) ? digits[i] : 0;
        end
        while (len > 0) begin
            rem  = 0;
            nlen = 0;
            for (int i = 0; i < len; i++) begin
                acc = rem * radix_in + work[i];
                rem = acc % divisor;
                if (acc / divisor != 0 || nlen != 0) begin
                    work[nlen] = acc / divisor;
                    nlen++;
                end
            end
            len = nlen;
            rem_digits.push_front(rem);
        end
    endfunction

    function void add_output(input logic [7:0] value, input logic eor, input t_err_kind ek);
        t_out_item item;
        item.value      = value;
        item.end_of_run = eor;
        item.error_kind = ek;
        out_wanted = {out_wanted, item};
    endfunction

    function void take_symbol(input t_in_item it);
        logic [7:0] v;
        logic [7:0] packed_byte;
        int unsigned i;
        if (n_digits >= MAX_LEN) begin
            if (err_seen == ERR_NONE) err_seen = ERR_TOO_LONG;
        end else begin
            if (!symbol_digit(mode, it.symbol, v) && err_seen == ERR_NONE) begin
                err_seen = ERR_BAD_CHAR;
            end
            digits[n_digits] = v;
            n_digits++;
        end
        if (!it.last) return;

        if (err_seen != ERR_NONE) begin
            add_output(8'd0, 1'b1, err_seen);
        end else begin
            if (mode == MODE_HEX) begin
                // Odd length: the first digit stands alone as a half byte.
                i = n_digits & 1;
                if (i != 0) add_output(digits[0], 1'b0, ERR_NONE);
                for (; i + 1 < n_digits; i += 2) begin
                    packed_byte = digits[i] * 8'd16 + digits[i + 1];
                    add_output(packed_byte, 1'b0, ERR_NONE);
                end
            end else if (mode == MODE_DEC) begin
                long_divide(10, 256);
                foreach (rem_digits[k]) add_output(8'(rem_digits[k]), 1'b0, ERR_NONE);
            end else begin
                long_divide(256, 10);
                foreach (rem_digits[k]) add_output(8'(rem_digits[k]) + CH_0, 1'b0, ERR_NONE);
            end
            if (out_wanted.size() > 0) begin
                out_wanted[out_wanted.size() - 1].end_of_run = 1'b1;
            end
        end
        n_digits = 0;
        err_seen = ERR_NONE;
    endfunction

    function void check_output(input t_out_item got);
        t_out_item want;
        if (out_wanted.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected transfer: value=%h eor=%b err=%0d",
                         got.value, got.end_of_run, got.error_kind);
            end
            return;
        end
        want = out_wanted.pop_front();
        if (got.value !== want.value || got.end_of_run !== want.end_of_run ||
            got.error_kind !== want.error_kind) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: exp value=%h eor=%b err=%0d, got value=%h eor=%b err=%0d",
                         want.value, want.end_of_run, want.error_kind,
                         got.value, got.end_of_run, got.error_kind);
            end
        end
    endfunction
endclass

module tb_top;

    localparam int RANDOM_ITEMS   = 280;
    localparam int PHASES         = 8;
    localparam int SETTLE_CYCLES  = 64;
    localparam int TIMEOUT_CYCLES = 500000;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_data = 2'd0;
    logic       i_valid    = 1'b0;
    logic       o_ready;
    t_in_item   i_in       = '0;
    logic       o_valid;
    logic       i_ready    = 1'b0;
    t_out_item  o_out;

    conversion_board board = new();
    int burst_left = 0;
    int random_items = 0;

    radix_converter_base256 DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: ready and stall stretches of random length, now and then a long free run.
    initial begin
        int  hold;
        bit  level;
        forever begin
            level = ($urandom_range(0, 2) != 0);
            if (level) begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 20);
            end else begin
                hold = $urandom_range(1, 8);
            end
            repeat (hold) begin
                @(posedge i_clk);
                i_ready <= level;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) board.check_output(o_out);
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_item(input logic [7:0] s, input logic l);
        int       gap;
        t_in_item it;
        it.symbol = s;
        it.last   = l;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_in    <= it;
        do @(posedge i_clk); while (!o_ready);
        board.take_symbol(it);
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_mode(m);
    endtask

    task automatic send_string(input logic [7:0] syms[$]);
        foreach (syms[k]) send_item(syms[k], k == syms.size() - 1);
    endtask

    function automatic logic [7:0] good_symbol(input logic [1:0] m, input int fill);
        int r;
        if (m == MODE_DEC) begin
            if (fill == 0) return CH_0;
            if (fill == 1) return CH_9;
            return CH_0 + 8'($urandom_range(0, 9));
        end
        if (m == MODE_HEX) begin
            if (fill == 0) return CH_0;
            if (fill == 1) return ($urandom_range(0, 1) != 0) ? CH_LF : CH_UF;
            r = $urandom_range(0, 21);
            if (r < 10) return CH_0 + 8'(r);
            if (r < 16) return CH_UA + 8'(r - 10);
            return CH_LA + 8'(r - 16);
        end
        if (fill == 0) return 8'h00;
        if (fill == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] bad_symbol(input logic [1:0] m);
        logic [7:0] s;
        logic [7:0] v;
        // Byte modes accept every symbol; fall back to a plain one.
        if (m >= MODE_BYTES) return 8'($urandom_range(0, 255));
        do s = 8'($urandom_range(0, 255)); while (board.symbol_digit(m, s, v));
        return s;
    endfunction

    // One number: mostly clean, some with a bad character, some too long, a few at full length.
    task automatic send_run(input logic [1:0] m);
        int         kind;
        int         len;
        int         bad_at;
        int         fill;
        int         held;
        logic [7:0] s;
        kind = $urandom_range(0, 19);
        if (kind == 19) begin
            len = MAX_LEN;
        end else if (kind >= 16) begin
            len = $urandom_range(MAX_LEN + 1, MAX_LEN + 3);
        end else if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(7, 16);
        end else begin
            len = $urandom_range(1, 6);
        end
        held = (len < MAX_LEN) ? len : MAX_LEN;
        bad_at = (kind == 14 || kind == 15 || kind == 18) ? $urandom_range(0, held - 1) : -1;
        fill = $urandom_range(0, 7);
        for (int i = 0; i < len; i++) begin
            s = (i == bad_at) ? bad_symbol(m) : good_symbol(m, fill);
            send_item(s, i == len - 1);
            random_items++;
        end
    endtask

    initial begin
        int         offset;
        int         phase_goal;
        logic [1:0] m;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, leading zeros, bad characters, odd hex, byte extremes, mode three.
        write_mode(MODE_DEC);
        send_string('{CH_0});
        send_string('{CH_0, CH_0, 8'h32, 8'h35, 8'h36});
        send_string('{CH_9, 8'h78});
        send_string('{8'h00});
        wait_idle();
        write_mode(MODE_HEX);
        send_string('{CH_0, CH_LA, CH_UF});
        send_string('{8'h47, 8'h31});
        send_string('{8'hFF});
        wait_idle();
        write_mode(MODE_BYTES);
        send_string('{8'h00});
        send_string('{8'hFF, 8'hFF});
        wait_idle();
        write_mode(MODE_BYTES_ALT);
        send_string('{8'h01, 8'h00});
        wait_idle();

        // Random phases; the mode rotates so each value comes up twice.
        offset = $urandom_range(0, 3);
        for (int p = 0; p < PHASES; p++) begin
            m = 2'((p + offset) % 4);
            write_mode(m);
            phase_goal = (RANDOM_ITEMS * (p + 1)) / PHASES;
            while (random_items < phase_goal) send_run(m);
            wait_idle();
        end

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
